// ----- src/start_end_comma_frame_parser_macros.svh -----
// ----------------------------------------------------------------------------
// start_end_comma_frame_parser_macros
// assertion shorthands for the frame parser checker
// ----------------------------------------------------------------------------
`ifndef START_END_COMMA_FRAME_PARSER_MACROS_SVH
`define START_END_COMMA_FRAME_PARSER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SEFP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sefp: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define SEFP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sefp: next-cycle check failed");

`endif

// ----- src/sefp_pkg.sv -----
// ----------------------------------------------------------------------------
// sefp_pkg
// shared sizes, byte codes and request/result types of the frame parser
// ----------------------------------------------------------------------------
package sefp_pkg;

	// frame geometry
	localparam int MAX_FIELDS  = 8;
	localparam int FIELD_BYTES = 16;

	localparam int FIDX_W    = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
	localparam int BOFF_W    = (FIELD_BYTES > 1) ? $clog2(FIELD_BYTES) : 1;
	localparam int BIDX_W    = $clog2(FIELD_BYTES + 1);
	localparam int CNT_W     = $clog2(MAX_FIELDS + 1);
	localparam int ADDR_W    = 1 + FIDX_W + BOFF_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;

	localparam int DEC_BASE = 10;

	// request commands
	localparam logic CMD_RECEIVE = 1'b0;
	localparam logic CMD_QUERY   = 1'b1;

	// byte codes
	localparam logic [7:0] CH_START = 8'h73;
	localparam logic [7:0] CH_END   = 8'h65;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [2:0] TYPE_P = 3'd7;

	// store write port, commit swaps banks
	typedef struct packed {
		logic              en;
		logic              commit;
		logic [FIDX_W-1:0] field;
		logic [BOFF_W-1:0] off;
		logic [7:0]        data;
	} sefp_wr_t;

	// store read port, always from the committed bank
	typedef struct packed {
		logic              en;
		logic [FIDX_W-1:0] field;
		logic [BOFF_W-1:0] off;
	} sefp_rd_t;

	// one result item
	typedef struct packed {
		logic        frame_done;
		logic        frame_open;
		logic [2:0]  data_type;
		logic [3:0]  field_count;
		logic [4:0]  last_field_length;
		logic [15:0] query_value;
		logic        query_nondigit;
	} sefp_res_t;

endpackage

// ----- src/sefp_in_if.sv -----
// ----------------------------------------------------------------------------
// sefp_in_if
// request channel of the frame parser: receive byte or field query
// ----------------------------------------------------------------------------
interface sefp_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] rx_byte;
	logic [2:0] field_select;

	modport source (output valid, command, rx_byte, field_select, input ready);
	modport sink   (input valid, command, rx_byte, field_select, output ready);
endinterface

// ----- src/sefp_out_if.sv -----
// ----------------------------------------------------------------------------
// sefp_out_if
// result channel of the frame parser
// ----------------------------------------------------------------------------
interface sefp_out_if;
	logic        valid;
	logic        ready;
	logic        frame_done;
	logic        frame_open;
	logic [2:0]  data_type;
	logic [3:0]  field_count;
	logic [4:0]  last_field_length;
	logic [15:0] query_value;
	logic        query_nondigit;

	modport source (
		output valid, frame_done, frame_open, data_type, field_count,
		       last_field_length, query_value, query_nondigit,
		input  ready
	);
	modport sink (
		input  valid, frame_done, frame_open, data_type, field_count,
		       last_field_length, query_value, query_nondigit,
		output ready
	);
endinterface

// ----- src/sefp_store.sv -----
// ----------------------------------------------------------------------------
// sefp_store
// two-bank byte memory: one bank collects the open frame, the other holds
// the committed frame; commit swaps the banks and empties the new work bank
// ----------------------------------------------------------------------------
module sefp_store
	import sefp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  sefp_wr_t   wr,
	input  sefp_rd_t   rd,
	output logic [7:0] rdata
);

	logic                wbank_q;
	logic [BIDX_W-1:0]   fill_q [2][MAX_FIELDS];
	logic [7:0]          mem [MEM_DEPTH];
	logic [7:0]          rdata_s1;
	logic                rvld_s1;
	logic [ADDR_W-1:0]   waddr;
	logic [ADDR_W-1:0]   raddr;
	logic [BIDX_W-1:0]   wfill;

	assign waddr = {wbank_q, wr.field, wr.off};
	assign raddr = {~wbank_q, rd.field, rd.off};
	assign wfill = BIDX_W'(wr.off) + BIDX_W'(1);

	// per-row fill marks: bytes below the mark were written, the rest read zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wbank_q <= 1'b0;
			for (int b = 0; b < 2; b++) begin
				for (int f = 0; f < MAX_FIELDS; f++) begin
					fill_q[b][f] <= '0;
				end
			end
		end else if (wr.commit) begin
			wbank_q <= ~wbank_q;
			for (int f = 0; f < MAX_FIELDS; f++) begin
				fill_q[~wbank_q][f] <= '0;
			end
		end else if (wr.en) begin
			if (wfill > fill_q[wbank_q][wr.field]) begin
				fill_q[wbank_q][wr.field] <= wfill;
			end
		end
	end

	// byte array, registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[waddr] <= wr.data;
		end
		if (rd.en) begin
			rdata_s1 <= mem[raddr];
			rvld_s1  <= (BIDX_W'(rd.off) < fill_q[~wbank_q][rd.field]);
		end
	end

	assign rdata = rvld_s1 ? rdata_s1 : 8'h00;

endmodule

// ----- src/sefp_ctrl.sv -----
// ----------------------------------------------------------------------------
// sefp_ctrl
// byte receive state, field lengths and the decimal query sequencer
// ----------------------------------------------------------------------------
module sefp_ctrl
	import sefp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  logic       command,
	input  logic [7:0] rx_byte,
	input  logic [2:0] field_select,
	output logic       ready,
	input  logic       take,
	output sefp_res_t  hold,
	output logic       hold_valid,
	output sefp_wr_t   wr,
	output sefp_rd_t   rd,
	input  logic [7:0] rdata
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_QUERY = 2'b10
	} sefp_state_t;

	sefp_state_t       state_q;

	// frame state
	logic              receiving_q, type_pending_q, end_flag_q;
	logic [2:0]        type_code_q;
	logic [FIDX_W-1:0] fidx_q;
	logic [BIDX_W-1:0] bidx_q;
	logic [CNT_W-1:0]  ccount_q;
	logic [BIDX_W-1:0] clast_q;
	logic [BIDX_W-1:0] flen_q [MAX_FIELDS];

	logic              nxt_receiving, nxt_type_pending, nxt_end_flag;
	logic [2:0]        nxt_type_code;
	logic [FIDX_W-1:0] nxt_fidx;
	logic [BIDX_W-1:0] nxt_bidx;
	logic [CNT_W-1:0]  nxt_ccount;
	logic [BIDX_W-1:0] nxt_clast;
	logic              flen_we;

	// query sequencer
	logic [FIDX_W-1:0] sel_q;
	logic [BIDX_W-1:0] qlen_q, issue_q, proc_q;
	logic [15:0]       sum_q;
	logic              rd_vld_s1;

	logic              rx_acc, qy_acc;
	logic [FIDX_W-1:0] q_sel;
	logic              q_inrange;
	logic [BIDX_W-1:0] q_len;
	logic              q_start;
	logic              q_bad;
	logic [7:0]        q_digit;
	logic [15:0]       q_nsum;
	logic              q_fin;
	logic [15:0]       q_val;
	logic              hold_load;

	assign rx_acc = acc && (command == CMD_RECEIVE);
	assign qy_acc = acc && (command == CMD_QUERY);
	assign ready  = (state_q == ST_IDLE) && !hold_valid;

	// byte decode and next frame state
	always_comb begin
		nxt_receiving    = receiving_q;
		nxt_type_pending = type_pending_q;
		nxt_end_flag     = end_flag_q;
		nxt_type_code    = type_code_q;
		nxt_fidx         = fidx_q;
		nxt_bidx         = bidx_q;
		nxt_ccount       = ccount_q;
		nxt_clast        = clast_q;
		flen_we          = 1'b0;
		wr               = '0;
		if (rx_acc) begin
			priority if (rx_byte == CH_START) begin
				nxt_receiving    = 1'b1;
				nxt_end_flag     = 1'b0;
				nxt_type_pending = 1'b1;
				nxt_bidx         = '0;
				nxt_fidx         = '0;
			end else if (rx_byte == CH_END) begin
				flen_we       = 1'b1;
				nxt_receiving = 1'b0;
				nxt_end_flag  = 1'b1;
				nxt_clast     = bidx_q;
				nxt_ccount    = CNT_W'(fidx_q) + CNT_W'(1);
				nxt_fidx      = '0;
				nxt_bidx      = '0;
				wr.commit     = 1'b1;
			end else if (rx_byte == CH_COMMA) begin
				flen_we = 1'b1;
				if (32'(fidx_q) < MAX_FIELDS - 1) begin
					nxt_fidx = fidx_q + FIDX_W'(1);
				end
				nxt_bidx = '0;
			end else begin
				if (type_pending_q) begin
					if (rx_byte >= CH_ONE && rx_byte <= CH_SIX) begin
						nxt_type_code = 3'(rx_byte - CH_ZERO);
					end else if (rx_byte == CH_P) begin
						nxt_type_code = TYPE_P;
					end
					nxt_type_pending = 1'b0;
				end
				// bytes past a full field are dropped
				if (receiving_q && (32'(bidx_q) < FIELD_BYTES)) begin
					wr.en    = 1'b1;
					wr.field = fidx_q;
					wr.off   = BOFF_W'(bidx_q);
					wr.data  = rx_byte;
					nxt_bidx = bidx_q + BIDX_W'(1);
				end
			end
		end
	end

	// query setup
	assign q_sel     = FIDX_W'(field_select);
	assign q_inrange = (32'(field_select) < 32'(ccount_q)) && (32'(field_select) < MAX_FIELDS);
	assign q_len     = flen_q[q_sel];
	assign q_start   = qy_acc && q_inrange && (q_len != '0);

	// one committed byte per cycle, each read issued in the cycle before its byte is used
	assign q_bad   = (rdata < CH_ZERO) || (rdata > CH_NINE);
	assign q_digit = rdata - CH_ZERO;
	assign q_nsum  = 16'(sum_q * 16'(DEC_BASE)) + {8'h00, q_digit};
	assign q_fin   = (state_q == ST_QUERY) && rd_vld_s1
		&& (q_bad || ((proc_q + BIDX_W'(1)) == qlen_q));
	assign q_val   = q_bad ? {8'h00, rdata} : q_nsum;

	always_comb begin
		rd.en    = (state_q == ST_QUERY) && (issue_q < qlen_q) && !q_fin;
		rd.field = sel_q;
		rd.off   = BOFF_W'(issue_q);
	end

	assign hold_load = rx_acc || (qy_acc && !q_start) || q_fin;

	// control and frame registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rd_vld_s1      <= 1'b0;
			hold_valid     <= 1'b0;
			receiving_q    <= 1'b0;
			type_pending_q <= 1'b0;
			end_flag_q     <= 1'b0;
			type_code_q    <= '0;
			fidx_q         <= '0;
			bidx_q         <= '0;
			ccount_q       <= '0;
			clast_q        <= '0;
			for (int f = 0; f < MAX_FIELDS; f++) begin
				flen_q[f] <= '0;
			end
		end else begin
			receiving_q    <= nxt_receiving;
			type_pending_q <= nxt_type_pending;
			end_flag_q     <= nxt_end_flag;
			type_code_q    <= nxt_type_code;
			fidx_q         <= nxt_fidx;
			bidx_q         <= nxt_bidx;
			ccount_q       <= nxt_ccount;
			clast_q        <= nxt_clast;
			if (flen_we) begin
				flen_q[fidx_q] <= bidx_q;
			end
			rd_vld_s1 <= rd.en;
			unique case (state_q)
				ST_IDLE: begin
					if (q_start) begin
						state_q <= ST_QUERY;
					end
				end
				ST_QUERY: begin
					if (q_fin) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (hold_load) begin
				hold_valid <= 1'b1;
			end else if (take) begin
				hold_valid <= 1'b0;
			end
		end
	end

	// query datapath and result holding register
	always_ff @(posedge clk) begin
		if (q_start) begin
			sel_q   <= q_sel;
			qlen_q  <= q_len;
			issue_q <= '0;
			proc_q  <= '0;
			sum_q   <= '0;
		end else begin
			if (rd.en) begin
				issue_q <= issue_q + BIDX_W'(1);
			end
			if (rd_vld_s1 && !q_fin) begin
				sum_q  <= q_nsum;
				proc_q <= proc_q + BIDX_W'(1);
			end
		end
		if (hold_load) begin
			hold.frame_done        <= nxt_end_flag;
			hold.frame_open        <= nxt_receiving;
			hold.data_type         <= nxt_type_code;
			hold.field_count       <= 4'(nxt_ccount);
			hold.last_field_length <= 5'(nxt_clast);
			hold.query_value       <= q_fin ? q_val : 16'h0000;
			hold.query_nondigit    <= q_fin && q_bad;
		end
	end

endmodule

// ----- src/start_end_comma_frame_parser.sv -----
// ----------------------------------------------------------------------------
// start_end_comma_frame_parser
// splits received bytes into comma separated fields of a frame opened by
// 's' and closed by 'e', and parses committed fields as decimal numbers
//
//   channel  | dir | payload                                   | handshake
//   item     | in  | command, rx_byte, field_select            | valid/ready
//   result   | out | frame_done, frame_open, data_type,        | valid/ready
//            |     | field_count, last_field_length,           |
//            |     | query_value, query_nondigit               |
//
// a receive request is decoded in the cycle it is taken; its result is
// registered in the holding register, then moves to the output register once free
// a query reads the stored field (len = stored field length, at most 16)
// through the single read port of the byte memory: one byte per cycle
// behind the registered read, ending early at the first non-digit
// one request is in flight at a time; a new request is taken while the
// previous result still waits in the output register
// reset clears the control and frame state; the byte memory needs no clearing pass
// ----------------------------------------------------------------------------
module start_end_comma_frame_parser
	import sefp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	sefp_in_if.sink     item,
	sefp_out_if.source  result
);

	sefp_res_t  hold;
	logic       hold_valid;
	logic       ready;
	logic       acc;
	logic       take;
	sefp_wr_t   wr;
	sefp_rd_t   rd;
	logic [7:0] rdata;
	sefp_res_t  out_q;
	logic       out_valid_q;

	assign item.ready = ready;
	assign acc        = item.valid && ready;
	assign take       = hold_valid && (!out_valid_q || result.ready);

	sefp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.command      (item.command),
		.rx_byte      (item.rx_byte),
		.field_select (item.field_select),
		.ready        (ready),
		.take         (take),
		.hold         (hold),
		.hold_valid   (hold_valid),
		.wr           (wr),
		.rd           (rd),
		.rdata        (rdata)
	);

	sefp_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd     (rd),
		.rdata  (rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			out_valid_q <= hold_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= hold;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.frame_done        = out_q.frame_done;
	assign result.frame_open        = out_q.frame_open;
	assign result.data_type         = out_q.data_type;
	assign result.field_count       = out_q.field_count;
	assign result.last_field_length = out_q.last_field_length;
	assign result.query_value       = out_q.query_value;
	assign result.query_nondigit    = out_q.query_nondigit;

endmodule

// ----- src/sefp_checker.sv -----
// ----------------------------------------------------------------------------
// sefp_checker
// port-level checks on the frame parser, attached by bind
// ----------------------------------------------------------------------------
`include "start_end_comma_frame_parser_macros.svh"

module sefp_checker
	import sefp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        frame_done,
	input logic        frame_open,
	input logic [3:0]  field_count,
	input logic [15:0] query_value,
	input logic        query_nondigit
);

	// one request in flight: taking a request closes the input in the cycle after
	`SEFP_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)

	// a frame is never open and done at once
	`SEFP_ASSERT_NOW(a_flags_exclusive, out_valid, !(frame_done && frame_open))

	// a reported non-digit is a byte code outside the digit range
	`SEFP_ASSERT_NOW(a_nondigit_code, out_valid && query_nondigit, (query_value[15:8] == 8'h00) && ((query_value[7:0] < CH_ZERO) || (query_value[7:0] > CH_NINE)))

	// committed field count stays within the field slots
	`SEFP_ASSERT_NOW(a_count_bound, out_valid, 32'(field_count) <= MAX_FIELDS)

	// a stalled result holds
	`SEFP_ASSERT_NXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(query_value) && $stable(field_count))

endmodule

bind start_end_comma_frame_parser sefp_checker u_sefp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (item.valid),
	.in_ready       (item.ready),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.frame_done     (result.frame_done),
	.frame_open     (result.frame_open),
	.field_count    (result.field_count),
	.query_value    (result.query_value),
	.query_nondigit (result.query_nondigit)
);
